@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define AST_CLKD(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define AST_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/slr_pkg.sv @@
package slr_pkg;

	// register indexes on the config port
	localparam logic REG_RATE_STEP = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_EMIT
	} slr_state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;        // latch the incoming frame
		logic take_first;  // no previous frame: incoming frame also becomes previous
		logic calc;        // form both products for the current phase
		logic emit;        // load output register, advance phase
		logic wrap;        // interpolation run done: phase -= 1.0, current -> previous
		logic finish;      // end of stream: clear phase and previous-frame flag
		logic tail;        // outputs being formed belong to the final-frame tail
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic have_prev;
		logic pos_done;    // phase has reached 1.0
		logic out_free;    // output register can take a result this cycle
		logic fin;         // latched frame is the last of the stream
	} dp_sts_t;

endpackage

@@ hw/rtl/slr_ctrl.sv @@
module slr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              s_tlast,
	input  slr_pkg::dp_sts_t  sts,
	output slr_pkg::dp_cmd_t  cmd
);
	import slr_pkg::*;

	slr_state_t state_q, state_d;
	logic       tail_q, tail_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tail_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			tail_q  <= tail_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		tail_d   = tail_q;
		cmd      = '0;
		cmd.tail = tail_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					if (sts.have_prev) begin
						tail_d  = 1'b0;
						state_d = ST_MUL;
					end else begin
						// first frame of a stream primes the history; if it is also the last, its tail is run
						cmd.take_first = 1'b1;
						if (s_tlast) begin
							tail_d  = 1'b1;
							state_d = ST_MUL;
						end
					end
				end
			end
			ST_MUL: begin
				if (!sts.pos_done) begin
					cmd.calc = 1'b1;
					state_d  = ST_EMIT;
				end else if (tail_q) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.wrap = 1'b1;
					if (sts.fin) begin
						tail_d = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_MUL;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/slr_datapath.sv @@
module slr_datapath #(
	parameter int SAMPLE_WIDTH        = 24,
	parameter int PHASE_FRACTION_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  slr_pkg::dp_cmd_t                 cmd,
	output slr_pkg::dp_sts_t                 sts,
	input  logic [PHASE_FRACTION_BITS+4:0]   rate_step,
	input  logic [SAMPLE_WIDTH-1:0]          left_in,
	input  logic [SAMPLE_WIDTH-1:0]          right_in,
	input  logic                             final_frame,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [SAMPLE_WIDTH-1:0]          left_out,
	output logic [SAMPLE_WIDTH-1:0]          right_out,
	output logic                             run_last
);
	import slr_pkg::*;

	localparam int SW     = SAMPLE_WIDTH;
	localparam int FB     = PHASE_FRACTION_BITS;
	localparam int POS_W  = FB + 5;
	localparam int PROD_W = SW + FB + 2;
	localparam logic [POS_W-1:0] PHASE_ONE = POS_W'(1) << FB;

	logic [SW-1:0]     cur_l_q, cur_r_q, prev_l_q, prev_r_q;
	logic              fin_q;
	logic              have_prev_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  pos_nx;

	logic signed [SW:0]       diff_l, diff_r;
	logic signed [FB:0]       frac_s;
	logic signed [PROD_W-1:0] prod_l, prod_r;
	logic signed [PROD_W-1:0] prod_l_s1, prod_r_s1;
	logic                     last_s1;
	logic                     last_d;

	logic              m_tvalid_q;
	logic [SW-1:0]     out_l_q, out_r_q;
	logic              out_last_q;

	assign pos_nx = pos_q + rate_step;

	// last output of this frame: the next phase leaves [0,1) and no tail follows
	assign last_d = (pos_nx[POS_W-1:FB] != '0) &&
		(cmd.tail || !fin_q || (pos_nx[POS_W-1:FB+1] != '0));

	assign diff_l = $signed({cur_l_q[SW-1], cur_l_q}) - $signed({prev_l_q[SW-1], prev_l_q});
	assign diff_r = $signed({cur_r_q[SW-1], cur_r_q}) - $signed({prev_r_q[SW-1], prev_r_q});
	assign frac_s = $signed({1'b0, pos_q[FB-1:0]});
	assign prod_l = diff_l * frac_s;
	assign prod_r = diff_r * frac_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			pos_q       <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cmd.take_first)
				have_prev_q <= 1'b1;
			else if (cmd.finish)
				have_prev_q <= 1'b0;

			if (cmd.emit)
				pos_q <= pos_nx;
			else if (cmd.wrap)
				pos_q <= pos_q - PHASE_ONE;
			else if (cmd.finish)
				pos_q <= '0;

			if (cmd.emit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// upper product bits are the arithmetic (floor) shift of the scaled difference
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cur_l_q <= left_in;
			cur_r_q <= right_in;
			fin_q   <= final_frame;
		end
		if (cmd.take_first) begin
			prev_l_q <= left_in;
			prev_r_q <= right_in;
		end else if (cmd.wrap) begin
			prev_l_q <= cur_l_q;
			prev_r_q <= cur_r_q;
		end
		if (cmd.calc) begin
			prod_l_s1 <= prod_l;
			prod_r_s1 <= prod_r;
			last_s1   <= last_d;
		end
		if (cmd.emit) begin
			out_l_q    <= prev_l_q + prod_l_s1[FB+SW-1:FB];
			out_r_q    <= prev_r_q + prod_r_s1[FB+SW-1:FB];
			out_last_q <= last_s1;
		end
	end

	assign sts.have_prev = have_prev_q;
	assign sts.pos_done  = (pos_q[POS_W-1:FB] != '0);
	assign sts.out_free  = !m_tvalid_q || m_tready;
	assign sts.fin       = fin_q;

	assign m_tvalid  = m_tvalid_q;
	assign left_out  = out_l_q;
	assign right_out = out_r_q;
	assign run_last  = out_last_q;

endmodule

@@ hw/rtl/stereo_linear_resampler_unit.sv @@
// Stereo linear-interpolation resampler.
// A taken frame is latched; for each output the products are registered in ST_MUL (multiply),
// then the sum is added into the output register in ST_EMIT once that register is free.
// A new frame is accepted only in ST_IDLE, after all outputs of the current frame;
// up to 32 outputs per frame, 64 on a final frame, which also runs its tail.
// Reset (arst_n low, async): step = 1.0, no previous frame, phase 0, output empty.
module stereo_linear_resampler_unit #(
	parameter int SAMPLE_WIDTH        = 24,
	parameter int PHASE_FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream: frames in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // left_in, right_in
	input  logic        s_tlast,                          // final_frame
	// master stream: resampled frames out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,  // left_out, right_out
	output logic        m_tlast,                          // run_last
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import slr_pkg::*;

	localparam int SW      = SAMPLE_WIDTH;
	localparam int FB      = PHASE_FRACTION_BITS;
	localparam int POS_W   = FB + 5;
	localparam int TDATA_W = ((2*SW+7)/8)*8;
	localparam logic [31:0] STEP_MIN = 32'(1) << (FB - 5);
	localparam logic [31:0] STEP_MAX = 32'(1) << (FB + 4);
	localparam logic [POS_W-1:0] STEP_RESET = POS_W'(1) << FB;

	logic [POS_W-1:0] rate_step_q;
	logic [31:0]      step_clamped;
	logic             cfg_wr;
	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [SW-1:0]    left_out, right_out;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RATE_STEP);

	always_comb begin
		if (pwdata < STEP_MIN)
			step_clamped = STEP_MIN;
		else if (pwdata > STEP_MAX)
			step_clamped = STEP_MAX;
		else
			step_clamped = pwdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rate_step_q <= STEP_RESET;
		else if (cfg_wr)
			rate_step_q <= step_clamped[POS_W-1:0];
	end

	assign prdata = (paddr[2] == REG_RATE_STEP) ? 32'(rate_step_q) : '0;

	slr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.sts      (sts),
		.cmd      (cmd)
	);

	slr_datapath #(
		.SAMPLE_WIDTH        (SAMPLE_WIDTH),
		.PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.rate_step   (rate_step_q),
		.left_in     (s_tdata[SW-1:0]),
		.right_in    (s_tdata[2*SW-1:SW]),
		.final_frame (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.left_out    (left_out),
		.right_out   (right_out),
		.run_last    (m_tlast)
	);

	assign m_tdata = TDATA_W'({right_out, left_out});

endmodule

@@ hw/rtl/slr_checker.sv @@
`include "assert_macros.svh"

module slr_checker #(
	parameter int SAMPLE_WIDTH        = 24,
	parameter int PHASE_FRACTION_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
	input logic        m_tlast,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);
	import slr_pkg::*;

	localparam int FB = PHASE_FRACTION_BITS;
	localparam logic [31:0] STEP_MIN = 32'(1) << (FB - 5);
	localparam logic [31:0] STEP_MAX = 32'(1) << (FB + 4);

	logic out_stall;
	logic step_sel;
	logic step_ok;

	assign out_stall = m_tvalid && !m_tready;
	assign step_sel  = (paddr[2] == REG_RATE_STEP);
	assign step_ok   = psel && penable && pwrite && pready && step_sel &&
		(pwdata >= STEP_MIN) && (pwdata <= STEP_MAX);

	// a pending result is neither dropped nor altered while stalled
	`AST_CLKD(a_out_hold, clk, arst_n, out_stall |=> m_tvalid, "result dropped while stalled")
	`AST_CLKD(a_out_stable, clk, arst_n, out_stall |=> $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

	// an in-range step reads back exactly as written
	`AST_CLKD(a_step_readback, clk, arst_n, step_ok ##1 step_sel |-> prdata == $past(pwdata), "step readback mismatch")

	// the stored step never leaves the clamp range
	`AST_CLKD(a_step_range, clk, arst_n, step_sel |-> prdata >= STEP_MIN && prdata <= STEP_MAX, "step outside clamp range")

	// config port never inserts wait states
	`AST_ALWAYS(a_pready_high, clk, pready, "pready low")

endmodule

bind stereo_linear_resampler_unit slr_checker #(
	.SAMPLE_WIDTH        (SAMPLE_WIDTH),
	.PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
) u_slr_checker (.*);
